// ===== rtl/db2dwt_pkg.sv =====
// ----------------------------------------------------------------------------
// db2dwt_pkg
// Shared constants and types for the single-level db2 wavelet analysis block.
// ----------------------------------------------------------------------------
package db2dwt_pkg;

   localparam int DEF_SAMPLE_WIDTH   = 16;
   localparam int DEF_COEF_FRAC_BITS = 15;

   // filter length, one cell per tap
   localparam int NUM_TAPS = 4;

   // coefficient magnitudes in units of 1e-5
   localparam longint TAP_MAG_A = 48296;
   localparam longint TAP_MAG_B = 83652;
   localparam longint TAP_MAG_C = 22414;
   localparam longint TAP_MAG_D = 12941;
   localparam longint TAP_SCALE = 100000;

   // result coefficient width and its saturation limits
   localparam int OUT_W = 17;
   localparam longint OUT_MAX = 65535;
   localparam longint OUT_MIN = -65536;

   typedef struct packed {
      logic valid;
      logic fin;
      logic too_short;
   } tag_type;

endpackage

// ===== rtl/db2dwt_req_if.sv =====
// ----------------------------------------------------------------------------
// db2dwt_req_if
// Sample channel: one signal sample per item, with an end-of-signal flag.
// ----------------------------------------------------------------------------
interface db2dwt_req_if
   import db2dwt_pkg::*;
#(
   parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample;
   logic                           last;

   modport source (output valid, output sample, output last, input ready);
   modport sink   (input valid, input sample, input last, output ready);
endinterface

// ===== rtl/db2dwt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// db2dwt_rsp_if
// Coefficient channel: one approximation/detail pair per item.
// ----------------------------------------------------------------------------
interface db2dwt_rsp_if
   import db2dwt_pkg::*;
;
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] approx;
   logic signed [OUT_W-1:0] detail;
   logic                    final_res;
   logic                    too_short;

   modport source (output valid, output approx, output detail, output final_res,
                   output too_short, input ready);
   modport sink   (input valid, input approx, input detail, input final_res,
                   input too_short, output ready);
endinterface

// ===== rtl/db2dwt_analysis_symmetric_unit.sv =====
// ----------------------------------------------------------------------------
// db2_dwt_analysis_symmetric_unit
// One-level db2 wavelet analysis with half-sample symmetric extension.
// ----------------------------------------------------------------------------
// Samples stream in one item per cycle on req_if unless the chain stalls;
// each odd-indexed sample yields one approximation/detail pair on rsp_if,
// and the sample flagged last yields the closing one or two pairs, the final
// one marked final_res. A signal of fewer than three samples gives a single
// zero pair with too_short set. When the item marked last yields two pairs,
// they leave the window stage one per cycle unless stalled, and req_if.ready
// stays low until the second has left. A pair passes the window register,
// four tap cells (one multiply-accumulate of each filter per cell) and the
// rounding register. Holding rsp_if.ready low while a pair waits in the
// result register freezes the whole chain, and req_if.ready drops with it;
// a waiting pair does not stop the next sample being taken while it drains.
module db2_dwt_analysis_symmetric_unit
   import db2dwt_pkg::*;
#(
   parameter int SAMPLE_WIDTH   = DEF_SAMPLE_WIDTH,
   parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
   input  logic          clock,
   input  logic          reset,
   db2dwt_req_if.sink    req_if,
   db2dwt_rsp_if.source  rsp_if
);

   localparam int COEF_W = COEF_FRAC_BITS + 1;
   localparam int ACC_W  = SAMPLE_WIDTH + COEF_FRAC_BITS + 3;

   localparam logic signed [COEF_W-1:0] TAP_A =
      COEF_W'(((TAP_MAG_A << COEF_FRAC_BITS) + TAP_SCALE / 2) / TAP_SCALE);
   localparam logic signed [COEF_W-1:0] TAP_B =
      COEF_W'(((TAP_MAG_B << COEF_FRAC_BITS) + TAP_SCALE / 2) / TAP_SCALE);
   localparam logic signed [COEF_W-1:0] TAP_C =
      COEF_W'(((TAP_MAG_C << COEF_FRAC_BITS) + TAP_SCALE / 2) / TAP_SCALE);
   localparam logic signed [COEF_W-1:0] TAP_D =
      COEF_W'(((TAP_MAG_D << COEF_FRAC_BITS) + TAP_SCALE / 2) / TAP_SCALE);

   localparam logic signed [COEF_W-1:0] LO_TAPS [NUM_TAPS] = '{TAP_A, TAP_B, TAP_C, -TAP_D};
   localparam logic signed [COEF_W-1:0] HI_TAPS [NUM_TAPS] = '{-TAP_D, -TAP_C, TAP_B, -TAP_A};

   logic                                  en;
   logic [NUM_TAPS-1:0][SAMPLE_WIDTH-1:0] win_chain [NUM_TAPS+1];
   tag_type                               tag_chain [NUM_TAPS+1];
   logic signed [ACC_W-1:0]               lo_chain  [NUM_TAPS+1];
   logic signed [ACC_W-1:0]               hi_chain  [NUM_TAPS+1];

   db2dwt_window #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_window (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .req_if  (req_if),
      .job_win (win_chain[0]),
      .job_tag (tag_chain[0])
   );

   assign lo_chain[0] = '0;
   assign hi_chain[0] = '0;

   for (genvar k = 0; k < NUM_TAPS; k++) begin : g_cell
      db2dwt_tap_cell #(
         .SAMPLE_WIDTH (SAMPLE_WIDTH),
         .COEF_W       (COEF_W),
         .ACC_W        (ACC_W),
         .TAP_IDX      (k),
         .LO_TAP       (LO_TAPS[k]),
         .HI_TAP       (HI_TAPS[k])
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .win_in  (win_chain[k]),
         .tag_in  (tag_chain[k]),
         .lo_in   (lo_chain[k]),
         .hi_in   (hi_chain[k]),
         .win_out (win_chain[k+1]),
         .tag_out (tag_chain[k+1]),
         .lo_out  (lo_chain[k+1]),
         .hi_out  (hi_chain[k+1])
      );
   end

   db2dwt_round #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS),
      .ACC_W          (ACC_W)
   ) u_round (
      .clock  (clock),
      .reset  (reset),
      .tag_in (tag_chain[NUM_TAPS]),
      .lo_in  (lo_chain[NUM_TAPS]),
      .hi_in  (hi_chain[NUM_TAPS]),
      .en     (en),
      .rsp_if (rsp_if)
   );

endmodule

// ===== rtl/db2dwt_window.sv =====
// ----------------------------------------------------------------------------
// db2dwt_window
// Sample history, phase tracking and window selection with mirrored ends.
// ----------------------------------------------------------------------------
module db2dwt_window
   import db2dwt_pkg::*;
#(
   parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   en,
   db2dwt_req_if.sink                             req_if,
   output logic [NUM_TAPS-1:0][SAMPLE_WIDTH-1:0]  job_win,
   output tag_type                                job_tag
);

   localparam logic [1:0] POS_SAT = 2'd3;

   logic signed [SAMPLE_WIDTH-1:0]         hist_ff [3];
   logic signed [SAMPLE_WIDTH-1:0]         hist_in [3];
   logic [1:0]                             pos_ff, pos_in;
   logic                                   odd_ff, odd_in;
   logic                                   pend_ff, pend_in;
   logic [NUM_TAPS-1:0][SAMPLE_WIDTH-1:0]  pend_win_ff, pend_win_in;
   logic [NUM_TAPS-1:0][SAMPLE_WIDTH-1:0]  job_win_ff, job_win_in;
   tag_type                                job_tag_ff, job_tag_in;
   logic signed [SAMPLE_WIDTH-1:0]         cur;
   logic                                   accept;

   function automatic logic [NUM_TAPS-1:0][SAMPLE_WIDTH-1:0] mk_win(
      input logic [SAMPLE_WIDTH-1:0] w0,
      input logic [SAMPLE_WIDTH-1:0] w1,
      input logic [SAMPLE_WIDTH-1:0] w2,
      input logic [SAMPLE_WIDTH-1:0] w3
   );
      return {w3, w2, w1, w0};
   endfunction

   // a last item with two pairs closes the port until the second is issued
   assign req_if.ready = en && !pend_ff;
   assign accept       = req_if.valid && req_if.ready;
   assign cur          = req_if.sample;

   always_comb begin
      hist_in     = hist_ff;
      pos_in      = pos_ff;
      odd_in      = odd_ff;
      pend_in     = pend_ff;
      pend_win_in = pend_win_ff;
      job_win_in  = job_win_ff;
      job_tag_in  = job_tag_ff;
      if (en) begin
         job_tag_in = '0;
         if (pend_ff) begin
            job_win_in       = pend_win_ff;
            job_tag_in.valid = 1'b1;
            job_tag_in.fin   = 1'b1;
            pend_in          = 1'b0;
         end else if (accept) begin
            if (req_if.last) begin
               job_tag_in.valid = 1'b1;
               if (pos_ff < 2'd2) begin
                  job_win_in           = '0;
                  job_tag_in.fin       = 1'b1;
                  job_tag_in.too_short = 1'b1;
               end else if (odd_ff) begin
                  // even length: regular pair, then one pair into the mirrored tail
                  job_win_in  = mk_win(hist_ff[2], hist_ff[1], hist_ff[0], cur);
                  pend_win_in = mk_win(hist_ff[0], cur, cur, hist_ff[0]);
                  pend_in     = 1'b1;
               end else begin
                  // odd length: both pairs run into the mirrored tail
                  job_win_in  = mk_win(hist_ff[1], hist_ff[0], cur, cur);
                  pend_win_in = mk_win(cur, cur, hist_ff[0], hist_ff[1]);
                  pend_in     = 1'b1;
               end
               hist_in[0] = '0;
               hist_in[1] = '0;
               hist_in[2] = '0;
               pos_in     = '0;
               odd_in     = 1'b0;
            end else begin
               if (pos_ff == 2'd1) begin
                  // second sample: window comes from the leading mirror
                  job_win_in       = mk_win(cur, hist_ff[0], hist_ff[0], cur);
                  job_tag_in.valid = 1'b1;
               end else if (pos_ff == POS_SAT && odd_ff) begin
                  job_win_in       = mk_win(hist_ff[2], hist_ff[1], hist_ff[0], cur);
                  job_tag_in.valid = 1'b1;
               end
               hist_in[2] = hist_ff[1];
               hist_in[1] = hist_ff[0];
               hist_in[0] = cur;
               if (pos_ff != POS_SAT) begin
                  pos_in = pos_ff + 2'd1;
               end
               odd_in = !odd_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff[0] <= '0;
         hist_ff[1] <= '0;
         hist_ff[2] <= '0;
         pos_ff     <= '0;
         odd_ff     <= 1'b0;
         pend_ff    <= 1'b0;
         job_tag_ff <= '0;
      end else begin
         hist_ff    <= hist_in;
         pos_ff     <= pos_in;
         odd_ff     <= odd_in;
         pend_ff    <= pend_in;
         job_tag_ff <= job_tag_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_win_ff <= pend_win_in;
      job_win_ff  <= job_win_in;
   end

   assign job_win = job_win_ff;
   assign job_tag = job_tag_ff;

endmodule

// ===== rtl/db2dwt_tap_cell.sv =====
// ----------------------------------------------------------------------------
// db2dwt_tap_cell
// One filter tap: adds its low-pass and high-pass products to the running sums
// and hands the window and sums on to the next cell.
// ----------------------------------------------------------------------------
module db2dwt_tap_cell
   import db2dwt_pkg::*;
#(
   parameter int SAMPLE_WIDTH            = DEF_SAMPLE_WIDTH,
   parameter int COEF_W                  = DEF_COEF_FRAC_BITS + 1,
   parameter int ACC_W                   = DEF_SAMPLE_WIDTH + DEF_COEF_FRAC_BITS + 3,
   parameter int TAP_IDX                 = 0,
   parameter logic signed [COEF_W-1:0] LO_TAP = '0,
   parameter logic signed [COEF_W-1:0] HI_TAP = '0
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   en,
   input  logic [NUM_TAPS-1:0][SAMPLE_WIDTH-1:0]  win_in,
   input  tag_type                                tag_in,
   input  logic signed [ACC_W-1:0]                lo_in,
   input  logic signed [ACC_W-1:0]                hi_in,
   output logic [NUM_TAPS-1:0][SAMPLE_WIDTH-1:0]  win_out,
   output tag_type                                tag_out,
   output logic signed [ACC_W-1:0]                lo_out,
   output logic signed [ACC_W-1:0]                hi_out
);

   logic signed [SAMPLE_WIDTH-1:0]        w;
   logic signed [SAMPLE_WIDTH+COEF_W-1:0] prod_lo, prod_hi;
   logic [NUM_TAPS-1:0][SAMPLE_WIDTH-1:0] win_ff;
   tag_type                               tag_ff;
   logic signed [ACC_W-1:0]               lo_ff, hi_ff;

   assign w       = $signed(win_in[TAP_IDX]);
   assign prod_lo = w * LO_TAP;
   assign prod_hi = w * HI_TAP;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (en) begin
         tag_ff <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         win_ff <= win_in;
         lo_ff  <= lo_in + ACC_W'(prod_lo);
         hi_ff  <= hi_in + ACC_W'(prod_hi);
      end
   end

   assign win_out = win_ff;
   assign tag_out = tag_ff;
   assign lo_out  = lo_ff;
   assign hi_out  = hi_ff;

endmodule

// ===== rtl/db2dwt_round.sv =====
// ----------------------------------------------------------------------------
// db2dwt_round
// Rounds both sums to sample scale, saturates and holds the result register.
// ----------------------------------------------------------------------------
module db2dwt_round
   import db2dwt_pkg::*;
#(
   parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS,
   parameter int ACC_W          = DEF_SAMPLE_WIDTH + DEF_COEF_FRAC_BITS + 3
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tag_type                 tag_in,
   input  logic signed [ACC_W-1:0] lo_in,
   input  logic signed [ACC_W-1:0] hi_in,
   output logic                    en,
   db2dwt_rsp_if.source            rsp_if
);

   localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);

   logic                    rsp_valid_ff;
   logic signed [OUT_W-1:0] approx_ff, detail_ff;
   logic                    fin_ff, short_ff;

   // round half up by floor, then clamp to the output range
   function automatic logic signed [OUT_W-1:0] sat_round(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0]                v;
      logic signed [ACC_W-COEF_FRAC_BITS-1:0] q;
      logic signed [63:0]                     qx;
      v  = acc + HALF;
      q  = $signed(v[ACC_W-1:COEF_FRAC_BITS]);
      qx = 64'(q);
      if (qx > OUT_MAX) begin
         qx = OUT_MAX;
      end else if (qx < OUT_MIN) begin
         qx = OUT_MIN;
      end
      return qx[OUT_W-1:0];
   endfunction

   // the whole chain advances whenever the result register is free or drained
   assign en = !rsp_valid_ff || rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= tag_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         approx_ff <= sat_round(lo_in);
         detail_ff <= sat_round(hi_in);
         fin_ff    <= tag_in.fin;
         short_ff  <= tag_in.too_short;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.approx    = approx_ff;
   assign rsp_if.detail    = detail_ff;
   assign rsp_if.final_res = fin_ff;
   assign rsp_if.too_short = short_ff;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the single-level db2 wavelet analysis unit. Directed
// signals and signals of random length are streamed in, every coefficient pair
// is predicted bit-exactly in the bench and compared against the result
// channel, with random idling on both the sample and the result side.
// ----------------------------------------------------------------------------
module tb_top;
   import db2dwt_pkg::*;

   localparam int SW = DEF_SAMPLE_WIDTH;
   localparam int FB = DEF_COEF_FRAC_BITS;

   // taps in fixed point, magnitudes rounded half away from zero
   localparam longint QA = ((TAP_MAG_A << FB) + TAP_SCALE / 2) / TAP_SCALE;
   localparam longint QB = ((TAP_MAG_B << FB) + TAP_SCALE / 2) / TAP_SCALE;
   localparam longint QC = ((TAP_MAG_C << FB) + TAP_SCALE / 2) / TAP_SCALE;
   localparam longint QD = ((TAP_MAG_D << FB) + TAP_SCALE / 2) / TAP_SCALE;

   localparam int IDLE_PCT = 32;

   typedef struct {
      logic signed [SW-1:0] sample;
      logic                 last;
   } sample_item_type;

   typedef struct {
      logic signed [OUT_W-1:0] approx;
      logic signed [OUT_W-1:0] detail;
      logic                    final_res;
      logic                    too_short;
   } coef_pair_type;

   logic clock;
   logic reset;

   db2dwt_req_if #(.SAMPLE_WIDTH(SW)) req_ch ();
   db2dwt_rsp_if                      rsp_ch ();

   db2_dwt_analysis_symmetric_unit #(
      .SAMPLE_WIDTH  (SW),
      .COEF_FRAC_BITS(FB)
   ) uut (
      .clock (clock),
      .reset (reset),
      .req_if(req_ch),
      .rsp_if(rsp_ch)
   );

   sample_item_type sample_q[$];
   coef_pair_type   coef_q[$];
   sample_item_type drive_item;
   coef_pair_type   got_pair;
   coef_pair_type   want_pair;

   int n_queued;
   int n_taken;
   int n_errors;
   bit sample_taken;

   // predictor state
   longint hist[3];
   int     seen;
   bit     odd_ph;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic longint round_sat(input longint acc);
      longint q;
      q = (acc + (longint'(1) <<< (FB - 1))) >>> FB;
      if (q > OUT_MAX) q = OUT_MAX;
      if (q < OUT_MIN) q = OUT_MIN;
      return q;
   endfunction

   task automatic push_window(input longint w0, input longint w1, input longint w2,
                              input longint w3, input logic fin);
      coef_pair_type p;
      longint a;
      longint d;
      a = QA * w0 + QB * w1 + QC * w2 - QD * w3;
      d = -QD * w0 - QC * w1 + QB * w2 - QA * w3;
      p.approx    = OUT_W'(round_sat(a));
      p.detail    = OUT_W'(round_sat(d));
      p.final_res = fin;
      p.too_short = 1'b0;
      coef_q.push_back(p);
   endtask

   task automatic predict_coefs(input logic signed [SW-1:0] s, input logic is_last);
      coef_pair_type p;
      longint c;
      longint h0;
      longint h1;
      longint h2;
      c  = longint'(s);
      h0 = hist[0];
      h1 = hist[1];
      h2 = hist[2];
      if (is_last) begin
         if (seen < 2) begin
            p.approx    = '0;
            p.detail    = '0;
            p.final_res = 1'b1;
            p.too_short = 1'b1;
            coef_q.push_back(p);
         end else if (odd_ph) begin
            // even length: regular pair, then one pair into the mirrored tail
            push_window(h2, h1, h0, c, 1'b0);
            push_window(h0, c, c, h0, 1'b1);
         end else begin
            push_window(h1, h0, c, c, 1'b0);
            push_window(c, c, h0, h1, 1'b1);
         end
         hist   = '{0, 0, 0};
         seen   = 0;
         odd_ph = 1'b0;
      end else begin
         // second sample sees the mirrored head
         if (seen == 1) push_window(c, h0, h0, c, 1'b0);
         else if (seen == 3 && odd_ph) push_window(h2, h1, h0, c, 1'b0);
         hist[2] = h1;
         hist[1] = h0;
         hist[0] = c;
         if (seen < 3) seen++;
         odd_ph = ~odd_ph;
      end
   endtask

   task automatic check_field(input string name, input logic [OUT_W-1:0] want,
                              input logic [OUT_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d (0x%h), actual %0d (0x%h)",
                  $time, name, $signed(want), want, $signed(got), got);
         n_errors++;
      end
   endtask

   function automatic bit idle_now();
      // calm stretch in the middle of the run
      if (n_taken >= 150 && n_taken < 260) return 1'b0;
      return $urandom_range(99) < IDLE_PCT;
   endfunction

   function automatic logic signed [SW-1:0] rand_sample();
      case ($urandom_range(9))
         0: return {1'b0, {(SW-1){1'b1}}};
         1: return {1'b1, {(SW-1){1'b0}}};
         2: return SW'($signed($urandom_range(15)) - 8);
         default: return SW'($urandom);
      endcase
   endfunction

   task automatic add_signal(input int len, input int kind);
      sample_item_type it;
      for (int i = 0; i < len; i++) begin
         case (kind)
            1: it.sample = {1'b0, {(SW-1){1'b1}}};
            2: it.sample = {1'b1, {(SW-1){1'b0}}};
            3: it.sample = i[0] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
            default: it.sample = rand_sample();
         endcase
         it.last = (i == len - 1);
         sample_q.push_back(it);
         n_queued++;
      end
   endtask

   // driver: inputs change on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || sample_taken) begin
         if (sample_q.size() > 0 && !idle_now()) begin
            drive_item = sample_q.pop_front();
            req_ch.valid  <= 1'b1;
            req_ch.sample <= drive_item.sample;
            req_ch.last   <= drive_item.last;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
      rsp_ch.ready <= !idle_now();
   end

   // monitor: take items and results on the rising edge
   always @(posedge clock) begin
      sample_taken = !reset && req_ch.valid && req_ch.ready;
      if (sample_taken) begin
         n_taken++;
         predict_coefs(req_ch.sample, req_ch.last);
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got_pair.approx    = rsp_ch.approx;
         got_pair.detail    = rsp_ch.detail;
         got_pair.final_res = rsp_ch.final_res;
         got_pair.too_short = rsp_ch.too_short;
         if (coef_q.size() == 0) begin
            $display("%0t: unexpected pair, expected none, actual approx %0d detail %0d",
                     $time, got_pair.approx, got_pair.detail);
            n_errors++;
         end else begin
            want_pair = coef_q.pop_front();
            check_field("approx", want_pair.approx, got_pair.approx);
            check_field("detail", want_pair.detail, got_pair.detail);
            check_field("final_res", want_pair.final_res, got_pair.final_res);
            check_field("too_short", want_pair.too_short, got_pair.too_short);
         end
      end
   end

   initial begin
      int len;
      reset         = 1'b1;
      req_ch.valid  = 1'b0;
      req_ch.sample = '0;
      req_ch.last   = 1'b0;
      rsp_ch.ready  = 1'b0;
      sample_taken  = 1'b0;
      n_queued      = 0;
      n_taken       = 0;
      n_errors      = 0;
      hist          = '{0, 0, 0};
      seen          = 0;
      odd_ph        = 1'b0;

      // directed: short signals, shortest full signals, extremes, alternation
      add_signal(1, 1);
      add_signal(2, 2);
      add_signal(3, 3);
      add_signal(4, 2);
      add_signal(5, 1);
      add_signal(6, 3);

      // random signals, mostly short, a few long ones
      while (n_queued < 420) begin
         if ($urandom_range(9) < 7) len = $urandom_range(12, 1);
         else len = $urandom_range(40, 13);
         add_signal(len, ($urandom_range(19) == 0) ? $urandom_range(3, 1) : 0);
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (n_taken < n_queued) @(posedge clock);
      while (coef_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (n_errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== db2_dwt_analysis_symmetric_unit.f =====
rtl/db2dwt_pkg.sv
rtl/db2dwt_req_if.sv
rtl/db2dwt_rsp_if.sv
rtl/db2dwt_window.sv
rtl/db2dwt_tap_cell.sv
rtl/db2dwt_round.sv
rtl/db2dwt_analysis_symmetric_unit.sv
tb/tb_top.sv
